// File: src/rtcfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcfc_pkg
// shared codes, packing widths and calendar helpers for the rtc command
// frame checker
// ----------------------------------------------------------------------------
package rtcfc_pkg;

	// command codes
	localparam logic [7:0] CMD_TIME   = 8'd1;
	localparam logic [7:0] CMD_DATE   = 8'd2;
	localparam logic [7:0] CMD_ALARM  = 8'd3;
	localparam logic [7:0] CMD_NACK   = 8'd4;
	localparam logic [7:0] CMD_RESEND = 8'd5;

	// exact payload lengths per command, and the largest length byte
	localparam logic [7:0] LEN_TIME  = 8'd4;
	localparam logic [7:0] LEN_DATE  = 8'd5;
	localparam logic [7:0] LEN_ALARM = 8'd3;
	localparam logic [7:0] LEN_MAX   = 8'd8;

	// raw bcd limits
	localparam logic [7:0] HOUR_LIMIT = 8'h24;
	localparam logic [7:0] MIN_LIMIT  = 8'h60;

	// record kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_TIME  = 2'd1;
	localparam logic [1:0] KIND_DATE  = 2'd2;
	localparam logic [1:0] KIND_ALARM = 2'd3;

	localparam logic [6:0] CENTURY_RESET = 7'd20;

	localparam int IN_BYTES  = 6;
	localparam int IN_W      = IN_BYTES * 8;
	localparam int OUT_W     = 62;
	localparam int OUT_PAD_W = ((OUT_W + 7) / 8) * 8;

	typedef struct packed {
		logic [2:0] weekday;
		logic [7:0] year_low;
		logic [6:0] century;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] second;
		logic [7:0] minute;
		logic [7:0] hour;
		logic [1:0] kind;
		logic       sent;
		logic       nack;
	} result_t;

	function automatic logic bcd_ok(input logic [7:0] b);
		return (b[3:0] <= 4'd9) && (b[7:4] <= 4'd9);
	endfunction

	// tens * 10 + ones, as shifts
	function automatic logic [6:0] bcd_dec(input logic [7:0] b);
		logic [6:0] t;
		t = {3'b000, b[7:4]};
		return (t << 3) + (t << 1) + {3'b000, b[3:0]};
	endfunction

	// (13m+3)/5 mod 7 with jan/feb taken as months 13/14
	function automatic logic [2:0] month_term(input logic [6:0] mo);
		logic [2:0] r;
		case (mo)
			7'd1:    r = 3'd6;
			7'd2:    r = 3'd2;
			7'd3:    r = 3'd1;
			7'd4:    r = 3'd4;
			7'd5:    r = 3'd6;
			7'd6:    r = 3'd2;
			7'd7:    r = 3'd4;
			7'd8:    r = 3'd0;
			7'd9:    r = 3'd3;
			7'd10:   r = 3'd5;
			7'd11:   r = 3'd1;
			7'd12:   r = 3'd3;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// mod 7 by folding octal digits, since 8 = 1 mod 7
	function automatic logic [2:0] mod7(input logic [7:0] x);
		logic [4:0] f1;
		logic [3:0] f2;
		f1 = {3'b000, x[7:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
		f2 = {2'b00, f1[4:3]} + {1'b0, f1[2:0]};
		return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
	endfunction

endpackage

// File: src/rtc_command_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_command_frame_checker
// checks single-frame rtc command payloads and answers with ack or nack
// ----------------------------------------------------------------------------
// One received payload enters per transaction on the s_ side and is checked in
// a single pass: the payload is registered, the time/date/alarm checks, bcd
// conversion, leap-year test and weekday computation run in one short block of
// logic, and the answer lands in an output register on the m_ side. The answer
// is valid on m_ once it passes from the payload register to the output
// register, which a held answer can stall; a new payload can be taken every
// cycle, also while an answer waits on m_tready, as long as the payload stage
// can move on (payloads that give no answer always move on). For a length byte
// of at most 8, time, date and alarm commands of the wrong length and unknown
// commands give no answer and leave the kept record alone. An ack carries the
// whole kept record after the update; a nack carries zeros. No clearing pass
// at reset: the record resets to kind none, zero fields and century 20.
// ----------------------------------------------------------------------------
module rtc_command_frame_checker
	import rtcfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// pci_byte, command, arg_first, arg_second, arg_third, arg_fourth
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// reply_nack, record_sent, record_kind, out_hour, out_minute, out_second,
	// out_day, out_month, out_century, out_year_low, out_weekday, zero pad
	output logic [OUT_PAD_W-1:0] m_tdata
);

	// payload stage
	logic             in_valid_s1;
	logic [IN_W-1:0]  in_data_s1;

	// kept record
	logic [1:0] kind_q;
	logic [7:0] hour_q, minute_q, second_q, day_q, month_q, year_low_q;
	logic [6:0] century_q;
	logic [2:0] weekday_q;

	// output register
	logic      out_valid_q;
	result_t   out_data_q;

	logic [7:0] pci, cmd, a1, a2, a3, a4;
	assign pci = in_data_s1[7:0];
	assign cmd = in_data_s1[15:8];
	assign a1  = in_data_s1[23:16];
	assign a2  = in_data_s1[31:24];
	assign a3  = in_data_s1[39:32];
	assign a4  = in_data_s1[47:40];

	// date decode
	logic [6:0] d_dec, mo_dec, ce_dec, yl_dec;
	logic       date_bcd_ok, date_range_ok, date_ok, leap;
	logic       early_month;
	logic [4:0] day_limit;
	logic [6:0] zy;
	logic [2:0] century_term;
	logic [7:0] wsum;
	logic [2:0] weekday_new;

	assign d_dec  = bcd_dec(a1);
	assign mo_dec = bcd_dec(a2);
	assign ce_dec = bcd_dec(a3);
	assign yl_dec = bcd_dec(a4);

	assign date_bcd_ok   = bcd_ok(a1) && bcd_ok(a2) && bcd_ok(a3) && bcd_ok(a4);
	assign date_range_ok = (mo_dec >= 7'd1) && (mo_dec <= 7'd12)
		&& (ce_dec >= 7'd19) && (ce_dec <= 7'd20);

	// 100 = 0 mod 4, so only the year within the century matters, except 2000
	assign leap = ((yl_dec[1:0] == 2'b00) && (yl_dec != 7'd0))
		|| ((yl_dec == 7'd0) && (ce_dec == 7'd20));

	always_comb begin
		case (mo_dec)
			7'd2:                        day_limit = leap ? 5'd29 : 5'd28;
			7'd4, 7'd6, 7'd9, 7'd11:     day_limit = 5'd30;
			default:                     day_limit = 5'd31;
		endcase
	end

	assign date_ok = date_bcd_ok && date_range_ok
		&& (d_dec >= 7'd1) && (d_dec <= {2'b00, day_limit});

	// jan and feb count as the year before; at year 00 that borrows a century
	assign early_month = (mo_dec < 7'd3);

	always_comb begin
		zy           = yl_dec;
		century_term = (ce_dec == 7'd20) ? 3'd0 : 3'd1;
		if (early_month) begin
			if (yl_dec == 7'd0) begin
				zy           = 7'd99;
				century_term = (ce_dec == 7'd20) ? 3'd1 : 3'd3;
			end else begin
				zy = yl_dec - 7'd1;
			end
		end
	end

	assign wsum = {5'b0, month_term(mo_dec)} + {1'b0, d_dec} + {1'b0, zy}
		+ {3'b0, zy[6:2]} + {5'b0, century_term};
	assign weekday_new = mod7(wsum);

	// decision
	logic pci_bad, answer, nack, upd_time, upd_alarm, upd_date;
	logic time_ok, alarm_ok;

	assign pci_bad  = (pci[7:4] != 4'd0) || (pci > LEN_MAX);
	assign time_ok  = (a1 < HOUR_LIMIT) && (a2 < MIN_LIMIT) && (a3 < MIN_LIMIT);
	assign alarm_ok = (a1 < HOUR_LIMIT) && (a2 < MIN_LIMIT);

	always_comb begin
		answer    = 1'b0;
		nack      = 1'b0;
		upd_time  = 1'b0;
		upd_alarm = 1'b0;
		upd_date  = 1'b0;
		if (pci_bad) begin
			answer = 1'b1;
			nack   = 1'b1;
		end else begin
			unique case (cmd)
				CMD_TIME: begin
					answer   = (pci == LEN_TIME);
					nack     = !time_ok;
					upd_time = (pci == LEN_TIME) && time_ok;
				end
				CMD_DATE: begin
					answer   = (pci == LEN_DATE);
					nack     = !date_ok;
					upd_date = (pci == LEN_DATE) && date_ok;
				end
				CMD_ALARM: begin
					answer    = (pci == LEN_ALARM);
					nack      = !alarm_ok;
					upd_alarm = (pci == LEN_ALARM) && alarm_ok;
				end
				CMD_NACK: begin
					answer = 1'b1;
					nack   = 1'b1;
				end
				CMD_RESEND: begin
					answer = 1'b1;
				end
				default: begin
					answer = 1'b0;
				end
			endcase
		end
	end

	// handshake: the payload stage moves on if it has no answer or a free slot
	logic s1_go;
	assign s1_go    = in_valid_s1 && (!answer || !out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_data_s1 <= s_tdata;
		end
	end

	// next kept record
	logic [1:0] kind_d;
	logic [7:0] hour_d, minute_d, second_d, day_d, month_d, year_low_d;
	logic [6:0] century_d;
	logic [2:0] weekday_d;

	always_comb begin
		kind_d     = kind_q;
		hour_d     = hour_q;
		minute_d   = minute_q;
		second_d   = second_q;
		day_d      = day_q;
		month_d    = month_q;
		century_d  = century_q;
		year_low_d = year_low_q;
		weekday_d  = weekday_q;
		if (upd_time) begin
			kind_d   = KIND_TIME;
			hour_d   = a1;
			minute_d = a2;
			second_d = a3;
		end
		if (upd_alarm) begin
			kind_d   = KIND_ALARM;
			hour_d   = a1;
			minute_d = a2;
		end
		if (upd_date) begin
			kind_d     = KIND_DATE;
			day_d      = a1;
			month_d    = a2;
			century_d  = ce_dec;
			year_low_d = a4;
			weekday_d  = weekday_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= KIND_NONE;
			hour_q     <= 8'd0;
			minute_q   <= 8'd0;
			second_q   <= 8'd0;
			day_q      <= 8'd0;
			month_q    <= 8'd0;
			century_q  <= CENTURY_RESET;
			year_low_q <= 8'd0;
			weekday_q  <= 3'd0;
		end else if (s1_go) begin
			kind_q     <= kind_d;
			hour_q     <= hour_d;
			minute_q   <= minute_d;
			second_q   <= second_d;
			day_q      <= day_d;
			month_q    <= month_d;
			century_q  <= century_d;
			year_low_q <= year_low_d;
			weekday_q  <= weekday_d;
		end
	end

	// answer payload: nack carries zeros
	result_t result_d;
	always_comb begin
		result_d = '0;
		result_d.nack = nack;
		if (!nack) begin
			result_d.sent     = 1'b1;
			result_d.kind     = kind_d;
			result_d.hour     = hour_d;
			result_d.minute   = minute_d;
			result_d.second   = second_d;
			result_d.day      = day_d;
			result_d.month    = month_d;
			result_d.century  = century_d;
			result_d.year_low = year_low_d;
			result_d.weekday  = weekday_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && answer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && answer) begin
			out_data_q <= result_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_PAD_W-OUT_W){1'b0}}, out_data_q};

	// checks
	a_century_range: assert property (@(posedge clk) disable iff (!arst_n)
		(century_q == 7'd19) || (century_q == 7'd20))
		else $error("kept century left 19..20");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		weekday_q <= 3'd6)
		else $error("kept weekday above 6");

	a_nack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.sent == !out_data_q.nack)
		&& (!out_data_q.nack || (out_data_q[OUT_W-1:1] == '0)))
		else $error("answer payload inconsistent with ack/nack");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !s1_go) |=> in_valid_s1 && $stable(in_data_s1))
		else $error("stalled payload lost");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> out_valid_q && $stable(out_data_q))
		else $error("pending answer overwritten");

endmodule
